[sv/hpid_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hpid_pkg;

    // Field widths
    localparam int INTEGRAL_WIDTH = 48;
    localparam int HEADING_W      = 13;
    localparam int DT_W           = 20;
    localparam int GAIN_W         = 16;
    localparam int MC_W           = 15;
    localparam int LIMIT_W        = 47;
    localparam int CORR_W         = 16;
    localparam int ERR_W          = 13;
    localparam int DELTA_W        = 14;
    localparam int WRAP_W         = 15;

    // Angle constants in 1/16 degree
    localparam int FULL_TURN = 5760;
    localparam int HALF_TURN = 2880;

    // Fixed-point scaling
    localparam int OUT_SHIFT = 8;
    localparam int DERIV_W   = 32;

    // Serial multiplier: signed multiplicand times unsigned multiplier
    localparam int MCAND_W    = (INTEGRAL_WIDTH - DT_W > 32) ? INTEGRAL_WIDTH - DT_W : 32;
    localparam int MPL_W      = DT_W;
    localparam int PROD_W     = MCAND_W + 1 + MPL_W;
    localparam int MUL_CNT_W  = $clog2(MPL_W);

    // Serial divider for the derivative
    localparam int DVD_W      = DELTA_W - 1 + DT_W;
    localparam int DVS_W      = DT_W;
    localparam int DIV_CNT_W  = $clog2(DVD_W);

    // Internal accumulator widths
    localparam int EDT_W   = 34;
    localparam int SAT_W   = INTEGRAL_WIDTH + 3;
    localparam int CLAMP_W = ((INTEGRAL_WIDTH > LIMIT_W) ? INTEGRAL_WIDTH : LIMIT_W) + 1;
    localparam int SUM_W   = PROD_W + 2;

    // APB port
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    typedef enum logic [2:0] {
        REG_ENABLE     = 3'd0,
        REG_GAIN_P     = 3'd1,
        REG_GAIN_I     = 3'd2,
        REG_GAIN_D     = 3'd3,
        REG_MAX_CORR   = 3'd4,
        REG_INT_LIMIT  = 3'd5
    } t_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_PROD,
        ST_INTEG,
        ST_CLAMP,
        ST_MUL_P,
        ST_MUL_I,
        ST_DIV,
        ST_MUL_D,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic                      start;
        logic signed [MCAND_W-1:0] mcand;
        logic [MPL_W-1:0]          mplier;
    } t_mul_req;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

endpackage
`default_nettype wire

[sv/heading_pid_with_wrap_and_antiwindup.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Signals                                   | Direction
// ---------+-------------------------------------------+----------
// input    | i_in_valid, o_in_stall, i_func, i_heading,| in
//          | i_step_time                               |
// output   | o_out_valid, i_out_stall, o_correction    | out
// config   | psel, penable, pwrite, paddr, pwdata,     | APB
//          | prdata, pready                            |
//
// A control step computes the error, then runs four shift-add multiplies in one shared multiplier:
// the error by the step time, after which the integral is updated and clamped, then the P and I
// terms, a restoring divide for the derivative, and the D term; it then loads the result.
// The next input transfer can be taken in the idle state that follows the load.
// Capture items and disabled or zero-time steps skip the computation and load a zero result.
// One item is in work at a time; o_in_stall is high until its result is loaded
// into the output register, which holds while i_out_stall is high.
// Synchronous active-low reset clears the state, config, target, integral, last error, zero and valid flags.
module heading_pid_with_wrap_and_antiwindup import hpid_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic                   i_func,
    input  wire logic [HEADING_W-1:0]   i_heading,
    input  wire logic [DT_W-1:0]        i_step_time,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic signed [CORR_W-1:0]    o_correction,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PADDR_W-1:0]     paddr,
    input  wire logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]          prdata,
    output logic                        pready
);

    localparam logic [SAT_W-1:0] IMAX =
        {{(SAT_W-INTEGRAL_WIDTH+1){1'b0}}, {(INTEGRAL_WIDTH-1){1'b1}}};
    localparam logic [SAT_W-1:0] IMIN =
        {{(SAT_W-INTEGRAL_WIDTH+1){1'b1}}, {(INTEGRAL_WIDTH-1){1'b0}}};
    localparam logic [DVD_W-1:0] DERIV_NEG_LIM = DVD_W'(64'h8000_0000);

    // Configuration registers
    logic                r_enable;
    logic [GAIN_W-1:0]   r_gain_p;
    logic [GAIN_W-1:0]   r_gain_i;
    logic [GAIN_W-1:0]   r_gain_d;
    logic [MC_W-1:0]     r_max_corr;
    logic [LIMIT_W-1:0]  r_int_limit;

    // Controller state and working registers
    t_state                           r_state;
    t_state                           n_state;
    logic [HEADING_W-1:0]             r_target;
    logic signed [INTEGRAL_WIDTH-1:0] r_integ;
    logic signed [ERR_W-1:0]          r_prev;
    logic [HEADING_W-1:0]             r_heading;
    logic [DT_W-1:0]                  r_dt;
    logic signed [ERR_W-1:0]          r_e;
    logic signed [DELTA_W-1:0]        r_delta;
    logic signed [EDT_W-1:0]          r_prod;
    logic signed [SUM_W-1:0]          r_sum;
    logic                             r_zero;
    logic                             r_out_valid;
    logic signed [CORR_W-1:0]         r_correction;

    logic                             w_in_acc;
    logic                             w_cfg_wr;
    logic                             w_out_free;
    logic signed [WRAP_W-1:0]         w_d;
    logic signed [WRAP_W-1:0]         w_fold;
    logic signed [ERR_W-1:0]          w_e;
    logic signed [DELTA_W-1:0]        w_delta;
    logic [DELTA_W-1:0]               w_abs_delta;
    logic signed [SAT_W-1:0]          w_sat_sum;
    logic signed [INTEGRAL_WIDTH-1:0] w_integ_sat;
    logic signed [CLAMP_W-1:0]        w_ic;
    logic signed [CLAMP_W-1:0]        w_lim;
    logic signed [INTEGRAL_WIDTH-1:0] w_integ_clamp;
    logic [DVD_W-1:0]                 w_negq;
    logic signed [DERIV_W-1:0]        w_deriv;
    logic signed [SUM_W-1:0]          w_shift;
    logic signed [SUM_W-1:0]          w_mc;
    logic signed [CORR_W-1:0]         w_res;

    t_mul_req                         w_mul_req;
    logic                             w_mul_done;
    logic signed [PROD_W-1:0]         w_mul_product;
    t_div_req                         w_div_req;
    logic                             w_div_done;
    logic [DVD_W-1:0]                 w_div_quotient;

    assign w_in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign w_cfg_wr   = psel && penable && pwrite;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Heading error folded into one half turn either side of zero.
    always_comb begin
        w_d = $signed({2'b00, r_heading}) - $signed({2'b00, r_target})
            + WRAP_W'(HALF_TURN);
        if (w_d < 0) begin
            w_fold = w_d + WRAP_W'(FULL_TURN);
        end else if (w_d >= WRAP_W'(FULL_TURN)) begin
            w_fold = w_d - WRAP_W'(FULL_TURN);
        end else begin
            w_fold = w_d;
        end
        w_e         = ERR_W'(w_fold - WRAP_W'(HALF_TURN));
        w_delta     = DELTA_W'(w_e) - DELTA_W'(r_prev);
        w_abs_delta = r_delta[DELTA_W-1] ? DELTA_W'(-r_delta) : DELTA_W'(r_delta);
    end

    // Saturating integral update and optional symmetric clamp.
    always_comb begin
        w_sat_sum = SAT_W'(r_integ) + SAT_W'(r_prod);
        if (w_sat_sum > $signed(IMAX)) begin
            w_integ_sat = INTEGRAL_WIDTH'($signed(IMAX));
        end else if (w_sat_sum < $signed(IMIN)) begin
            w_integ_sat = INTEGRAL_WIDTH'($signed(IMIN));
        end else begin
            w_integ_sat = INTEGRAL_WIDTH'(w_sat_sum);
        end
        w_ic  = CLAMP_W'(r_integ);
        w_lim = $signed(CLAMP_W'(r_int_limit));
        if (r_gain_i != '0 && w_ic > w_lim) begin
            w_integ_clamp = INTEGRAL_WIDTH'(w_lim);
        end else if (r_gain_i != '0 && w_ic < -w_lim) begin
            w_integ_clamp = INTEGRAL_WIDTH'(-w_lim);
        end else begin
            w_integ_clamp = r_integ;
        end
    end

    // Derivative quotient with sign and 32-bit saturation.
    always_comb begin
        w_negq = ~w_div_quotient + 1'b1;
        if (!r_delta[DELTA_W-1]) begin
            if (w_div_quotient[DVD_W-1:DERIV_W-1] != '0) begin
                w_deriv = {1'b0, {(DERIV_W-1){1'b1}}};
            end else begin
                w_deriv = $signed(w_div_quotient[DERIV_W-1:0]);
            end
        end else begin
            if (w_div_quotient > DERIV_NEG_LIM) begin
                w_deriv = {1'b1, {(DERIV_W-1){1'b0}}};
            end else begin
                w_deriv = $signed(w_negq[DERIV_W-1:0]);
            end
        end
    end

    // Final scaling and output clamp.
    always_comb begin
        w_shift = r_sum >>> OUT_SHIFT;
        w_mc    = $signed(SUM_W'(r_max_corr));
        if (r_zero) begin
            w_res = '0;
        end else if (w_shift > w_mc) begin
            w_res = CORR_W'(w_mc);
        end else if (w_shift < -w_mc) begin
            w_res = CORR_W'(-w_mc);
        end else begin
            w_res = CORR_W'(w_shift);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_func || !r_enable || i_step_time == '0) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_ERR;
                    end
                end
            end
            ST_ERR:      n_state = ST_MUL_PROD;
            ST_MUL_PROD: if (w_mul_done) n_state = ST_INTEG;
            ST_INTEG:    n_state = ST_CLAMP;
            ST_CLAMP:    n_state = ST_MUL_P;
            ST_MUL_P:    if (w_mul_done) n_state = ST_MUL_I;
            ST_MUL_I:    if (w_mul_done) n_state = ST_DIV;
            ST_DIV:      if (w_div_done) n_state = ST_MUL_D;
            ST_MUL_D:    if (w_mul_done) n_state = ST_FINISH;
            ST_FINISH:   if (w_out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: stall and unit launches.
    always_comb begin
        o_in_stall          = (r_state != ST_IDLE);
        w_mul_req.start     = (n_state != r_state) &&
                              (n_state == ST_MUL_PROD || n_state == ST_MUL_P ||
                               n_state == ST_MUL_I || n_state == ST_MUL_D);
        w_mul_req.mcand     = '0;
        w_mul_req.mplier    = '0;
        unique case (n_state)
            ST_MUL_PROD: begin
                w_mul_req.mcand  = MCAND_W'(w_e);
                w_mul_req.mplier = r_dt;
            end
            ST_MUL_P: begin
                w_mul_req.mcand  = MCAND_W'(r_e);
                w_mul_req.mplier = MPL_W'(r_gain_p);
            end
            ST_MUL_I: begin
                w_mul_req.mcand  = MCAND_W'(r_integ >>> DT_W);
                w_mul_req.mplier = MPL_W'(r_gain_i);
            end
            ST_MUL_D: begin
                w_mul_req.mcand  = MCAND_W'(w_deriv);
                w_mul_req.mplier = MPL_W'(r_gain_d);
            end
            default: begin
                w_mul_req.mcand  = '0;
                w_mul_req.mplier = '0;
            end
        endcase
        w_div_req.start    = (n_state == ST_DIV) && (r_state != ST_DIV);
        w_div_req.dividend = {w_abs_delta[DELTA_W-2:0], {DT_W{1'b0}}};
        w_div_req.divisor  = r_dt;
    end

    // State register and item bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_target    <= '0;
            r_integ     <= '0;
            r_prev      <= '0;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // A result loads the output register as soon as it is free.
            if (r_state == ST_FINISH && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_zero <= i_func || !r_enable || i_step_time == '0;
                        if (i_func) begin
                            r_target <= i_heading;
                            r_integ  <= '0;
                            r_prev   <= '0;
                        end
                    end
                end
                ST_ERR:   r_prev  <= w_e;
                ST_INTEG: r_integ <= w_integ_sat;
                ST_CLAMP: r_integ <= w_integ_clamp;
                default: begin
                end
            endcase
        end
    end

    // Working datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_heading <= i_heading;
            r_dt      <= i_step_time;
        end
        if (r_state == ST_ERR) begin
            r_e     <= w_e;
            r_delta <= w_delta;
            r_sum   <= '0;
        end
        if (r_state == ST_MUL_PROD && w_mul_done) begin
            r_prod <= EDT_W'(w_mul_product);
        end
        if ((r_state == ST_MUL_P || r_state == ST_MUL_I || r_state == ST_MUL_D)
                && w_mul_done) begin
            r_sum <= r_sum + SUM_W'(w_mul_product);
        end
        if (r_state == ST_FINISH && w_out_free) begin
            r_correction <= w_res;
        end
    end

    // Register writes from the APB port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_max_corr  <= '0;
            r_int_limit <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[PADDR_W-1:3])
                REG_ENABLE:    r_enable    <= pwdata[0];
                REG_GAIN_P:    r_gain_p    <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:    r_gain_i    <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:    r_gain_d    <= pwdata[GAIN_W-1:0];
                REG_MAX_CORR:  r_max_corr  <= pwdata[MC_W-1:0];
                REG_INT_LIMIT: r_int_limit <= pwdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (paddr[PADDR_W-1:3])
            REG_ENABLE:    prdata = PDATA_W'(r_enable);
            REG_GAIN_P:    prdata = PDATA_W'(r_gain_p);
            REG_GAIN_I:    prdata = PDATA_W'(r_gain_i);
            REG_GAIN_D:    prdata = PDATA_W'(r_gain_d);
            REG_MAX_CORR:  prdata = PDATA_W'(r_max_corr);
            REG_INT_LIMIT: prdata = PDATA_W'(r_int_limit);
            default:       prdata = '0;
        endcase
    end

    assign pready       = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_correction = r_correction;

    hpid_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mul_req),
        .o_done    (w_mul_done),
        .o_product (w_mul_product)
    );

    hpid_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_div_quotient)
    );

endmodule
`default_nettype wire

[sv/hpid_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
module hpid_mul import hpid_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_mul_req                  i_req,
    output logic                           o_done,
    output logic signed [PROD_W-1:0]       o_product
);

    logic signed [MCAND_W:0]   r_hi;
    logic [MPL_W-1:0]          r_lo;
    logic signed [MCAND_W-1:0] r_mcand;
    logic [MUL_CNT_W-1:0]      r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic signed [MCAND_W:0]   w_sum;

    // One multiplier bit per cycle: add the multiplicand, then shift right.
    always_comb begin
        w_sum = r_lo[0] ? r_hi + (MCAND_W+1)'(r_mcand) : r_hi;
    end

    // Control state of the shift-add sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == MUL_CNT_W'(MPL_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath of the partial product.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_hi    <= '0;
            r_lo    <= i_req.mplier;
            r_mcand <= i_req.mcand;
            r_cnt   <= '0;
        end else if (r_busy) begin
            r_hi  <= w_sum >>> 1;
            r_lo  <= {w_sum[0], r_lo[MPL_W-1:1]};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done    = r_done;
    assign o_product = $signed({r_hi, r_lo});

endmodule
`default_nettype wire

[sv/hpid_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module hpid_div import hpid_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_div_req          i_req,
    output logic                   o_done,
    output logic [DVD_W-1:0]       o_quotient
);

    logic [DVS_W-1:0]     r_rem;
    logic [DVD_W-1:0]     r_quo;
    logic [DVS_W-1:0]     r_divisor;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DVS_W:0]       w_trial;
    logic [DVS_W:0]       w_diff;
    logic                 w_ge;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        w_trial = {r_rem, r_quo[DVD_W-1]};
        w_ge    = w_trial >= {1'b0, r_divisor};
        w_diff  = w_trial - {1'b0, r_divisor};
    end

    // Control state of the division.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DIV_CNT_W'(DVD_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= '0;
            r_quo     <= i_req.dividend;
            r_divisor <= i_req.divisor;
            r_cnt     <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire
